FILE: rtl/speed_to_pulse_table_interpolator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the speed-to-pulse interpolator core
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPEED_TO_PULSE_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define SPEED_TO_PULSE_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define STPTI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STPTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stpti_pkg.sv
// ----------------------------------------------------------------------------
// stpti_pkg
// Shared constants and types of the speed-to-pulse interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stpti_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int SpeedStep  = 50;
  localparam int M50W       = $clog2(SpeedStep * TableDepth + 1);

  localparam int ValW  = 15;
  localparam int CmdW  = 16;
  localparam int MagW  = 17;
  localparam int DmW   = 16;
  localparam int ProdW = ValW + DmW;
  localparam int QuotW = ValW;
  localparam int StepW = $clog2(QuotW + 1);

  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 15;
  localparam int EntW     = 5;

  localparam logic [ValW-1:0] NeutralReset = 15'd1500;
  localparam logic [EntW-1:0] EntriesReset = 5'd16;

  typedef enum logic [CfgAddrW-1:0] {
    RegNeutralPulse = 1'b0,
    RegEntriesInUse = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ModeLoad    = 1'b0,
    ModeCommand = 1'b1
  } mode_e;

  typedef logic [ValW-1:0] val_t;

  typedef struct packed {
    val_t speed;
    val_t pulse;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/speed_to_pulse_table_interpolator_core.sv
// A load or a zero command raises done_o in the cycle after accept (busy stays low);
// an exact or clamped command first scans the n entries in use (n is 1..16), one
// table read per cycle, and an interpolated one then runs a multiply and a
// 15-step restoring divide. One command at a time; done_o is a one-cycle strobe.
// Reset (rst_ni low, async): idle, pulse 1500 us, 16 entries; table contents
// stay undefined until loaded.
// ----------------------------------------------------------------------------
// speed_to_pulse_table_interpolator_core
// Maps a signed speed command onto a pulse width through forward and reverse
// (speed, pulse) tables, by exact slot hit, end clamp or linear interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module speed_to_pulse_table_interpolator_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [stpti_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [stpti_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             mode_i,
  input  wire logic                             load_reverse_i,
  input  wire logic [3:0]                       entry_index_i,
  input  wire logic [14:0]                      entry_speed_i,
  input  wire logic [14:0]                      entry_pulse_i,
  input  wire logic signed [15:0]               command_speed_i,
  output logic                                  done_o,
  output logic [14:0]                           pulse_width_us_o,
  output logic signed [15:0]                    returned_speed_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StFin   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StDivGo = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;

  logic [2:0]                    state_q;
  logic [stpti_pkg::ValW-1:0]    neutral_q;
  logic [stpti_pkg::EntW-1:0]    entries_q;

  logic [stpti_pkg::MagW-1:0]    mag_q;
  logic                          neg_q;
  logic [stpti_pkg::CmdW-1:0]    cmd_q;
  logic [stpti_pkg::CntW-1:0]    n_q;
  logic [stpti_pkg::CntW-1:0]    idx_q;
  logic [stpti_pkg::CntW-1:0]    ev_q;
  logic                          ev_vld_q;
  logic [stpti_pkg::M50W-1:0]    m50_q;

  logic                          hit_q;
  logic                          lo_q;
  logic                          hi_q;
  logic                          found_q;
  stpti_pkg::val_t               hit_spd_q;
  stpti_pkg::val_t               hit_pul_q;
  stpti_pkg::val_t               lo_pul_q;
  stpti_pkg::val_t               hi_pul_q;
  stpti_pkg::val_t               prev_spd_q;
  stpti_pkg::val_t               prev_pul_q;
  stpti_pkg::val_t               p1_q;
  stpti_pkg::val_t               dvs_q;
  stpti_pkg::val_t               dpa_q;
  logic                          dneg_q;
  logic [stpti_pkg::DmW-1:0]     dm_q;
  logic [stpti_pkg::ProdW-1:0]   prod_q;

  logic                          done_q;
  stpti_pkg::val_t               pulse_q;
  logic [stpti_pkg::CmdW-1:0]    ret_q;

  logic                          accept;
  logic                          is_load;
  logic                          cmd_zero;
  logic [stpti_pkg::MagW-1:0]    cmd_ext;
  logic [stpti_pkg::MagW-1:0]    cmd_mag;
  logic [stpti_pkg::CntW-1:0]    n_sat;

  logic                          tbl_we;
  logic [stpti_pkg::IdxW:0]      tbl_waddr;
  stpti_pkg::entry_t             tbl_wdata;
  logic [stpti_pkg::IdxW:0]      tbl_raddr;
  stpti_pkg::entry_t             rdata;

  logic [stpti_pkg::MagW-1:0]    rd_spd_ext;
  logic                          le;
  logic                          ge;
  logic                          exact;
  logic                          last;
  logic [stpti_pkg::CmdW-1:0]    dp;
  logic [stpti_pkg::ProdW-1:0]   prod;

  logic                          div_start;
  logic                          div_done;
  logic [stpti_pkg::QuotW-1:0]   quot;
  logic [stpti_pkg::CmdW-1:0]    interp;

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign is_load  = (mode_i == stpti_pkg::ModeLoad);
  assign cmd_zero = (command_speed_i == '0);
  assign cmd_ext  = {command_speed_i[15], command_speed_i};
  assign cmd_mag  = command_speed_i[15] ? (stpti_pkg::MagW'(0) - cmd_ext) : cmd_ext;

  // saturate the entry count to 1..TableDepth
  always_comb begin
    if (entries_q == '0) begin
      n_sat = stpti_pkg::CntW'(1);
    end else if (32'(entries_q) > stpti_pkg::TableDepth) begin
      n_sat = stpti_pkg::CntW'(stpti_pkg::TableDepth);
    end else begin
      n_sat = stpti_pkg::CntW'(entries_q);
    end
  end

  assign tbl_we    = accept && is_load && (32'(entry_index_i) < stpti_pkg::TableDepth);
  assign tbl_waddr = {load_reverse_i, stpti_pkg::IdxW'(entry_index_i)};
  assign tbl_wdata = '{speed: entry_speed_i, pulse: entry_pulse_i};
  assign tbl_raddr = {neg_q, idx_q[stpti_pkg::IdxW-1:0]};

  stpti_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (rdata)
  );

  assign rd_spd_ext = stpti_pkg::MagW'(rdata.speed);
  assign le         = (mag_q <= rd_spd_ext);
  assign ge         = (mag_q >= rd_spd_ext);
  assign exact      = (mag_q == stpti_pkg::MagW'(m50_q));
  assign last       = (ev_q == n_q - stpti_pkg::CntW'(1));
  assign dp         = {1'b0, rdata.pulse} - {1'b0, prev_pul_q};
  assign prod       = stpti_pkg::ProdW'(dpa_q) * stpti_pkg::ProdW'(dm_q);

  assign div_start  = (state_q == StDivGo);

  stpti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign interp = dneg_q ? ({1'b0, p1_q} - stpti_pkg::CmdW'(quot))
                         : ({1'b0, p1_q} + stpti_pkg::CmdW'(quot));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= stpti_pkg::NeutralReset;
      entries_q <= stpti_pkg::EntriesReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        stpti_pkg::RegNeutralPulse: neutral_q <= cfg_wdata_i[stpti_pkg::ValW-1:0];
        stpti_pkg::RegEntriesInUse: entries_q <= cfg_wdata_i[stpti_pkg::EntW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      ev_q     <= '0;
      ev_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      lo_q     <= 1'b0;
      hi_q     <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      pulse_q  <= stpti_pkg::NeutralReset;
      ret_q    <= '0;
      n_q      <= stpti_pkg::CntW'(1);
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (is_load) begin
              ret_q  <= '0;
              done_q <= 1'b1;
            end else if (cmd_zero) begin
              pulse_q <= neutral_q;
              ret_q   <= '0;
              done_q  <= 1'b1;
            end else begin
              n_q      <= n_sat;
              idx_q    <= '0;
              ev_vld_q <= 1'b0;
              hit_q    <= 1'b0;
              lo_q     <= 1'b0;
              hi_q     <= 1'b0;
              found_q  <= 1'b0;
              state_q  <= StScan;
            end
          end
        end
        StScan: begin
          // read one slot per cycle, evaluate it in the following cycle
          idx_q    <= idx_q + stpti_pkg::CntW'(1);
          ev_q     <= idx_q;
          ev_vld_q <= 1'b1;
          if (ev_vld_q) begin
            if (exact) begin
              hit_q <= 1'b1;
            end
            if (ev_q == '0 && le) begin
              lo_q <= 1'b1;
            end
            if (ev_q != '0 && !found_q && le) begin
              found_q <= 1'b1;
            end
            if (last) begin
              hi_q     <= ge;
              ev_vld_q <= 1'b0;
              state_q  <= StFin;
            end
          end
        end
        StFin: begin
          if (hit_q) begin
            pulse_q <= hit_pul_q;
            ret_q   <= neg_q ? (stpti_pkg::CmdW'(0) - {1'b0, hit_spd_q}) : {1'b0, hit_spd_q};
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else if (lo_q) begin
            pulse_q <= lo_pul_q;
            ret_q   <= cmd_q;
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else if (hi_q) begin
            pulse_q <= hi_pul_q;
            ret_q   <= cmd_q;
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StDivGo;
        end
        StDivGo: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            pulse_q <= interp[stpti_pkg::ValW-1:0];
            ret_q   <= cmd_q;
            done_q  <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && accept && !is_load && !cmd_zero) begin
      mag_q <= cmd_mag;
      neg_q <= command_speed_i[15];
      cmd_q <= command_speed_i;
      m50_q <= stpti_pkg::M50W'(stpti_pkg::SpeedStep);
    end
    if (state_q == StScan && ev_vld_q) begin
      m50_q      <= m50_q + stpti_pkg::M50W'(stpti_pkg::SpeedStep);
      prev_spd_q <= rdata.speed;
      prev_pul_q <= rdata.pulse;
      if (exact) begin
        hit_spd_q <= rdata.speed;
        hit_pul_q <= rdata.pulse;
      end
      if (ev_q == '0) begin
        lo_pul_q <= rdata.pulse;
      end
      if (last) begin
        hi_pul_q <= rdata.pulse;
      end
      // capture the bracketing pair at the first slot at or above the magnitude
      if (ev_q != '0 && !found_q && le) begin
        p1_q   <= prev_pul_q;
        dvs_q  <= rdata.speed - prev_spd_q;
        dm_q   <= stpti_pkg::DmW'(mag_q - stpti_pkg::MagW'(prev_spd_q));
        dneg_q <= dp[stpti_pkg::CmdW-1];
        dpa_q  <= dp[stpti_pkg::CmdW-1] ? stpti_pkg::ValW'(stpti_pkg::CmdW'(0) - dp)
                                        : dp[stpti_pkg::ValW-1:0];
      end
    end
    if (state_q == StMul) begin
      prod_q <= prod;
    end
  end

  assign done_o           = done_q;
  assign pulse_width_us_o = pulse_q;
  assign returned_speed_o = ret_q;

`include "speed_to_pulse_table_interpolator_core_assert.svh"

  `STPTI_ASSERT_NEXT(a_cmd_busy, start && !busy && mode_i == stpti_pkg::ModeCommand && command_speed_i != '0, busy, "nonzero command did not start a scan")
  `STPTI_ASSERT_NEXT(a_quick_done, start && !busy && (mode_i == stpti_pkg::ModeLoad || command_speed_i == '0), done_o && !busy, "load or zero command gave no result")
  `STPTI_ASSERT_IMPL(a_done_idle, done_o, !busy, "result strobe while still busy")
  `STPTI_ASSERT_IMPL(a_div_state, div_done, state_q == StDiv, "divider finished outside the divide step")

endmodule

`default_nettype wire

FILE: rtl/stpti_table.sv
// ----------------------------------------------------------------------------
// stpti_table
// Forward and reverse (speed, pulse) table, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpti_table (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [stpti_pkg::IdxW:0] waddr_i,
  input  wire stpti_pkg::entry_t       wdata_i,
  input  wire logic [stpti_pkg::IdxW:0] raddr_i,
  output stpti_pkg::entry_t            rdata_o
);

  // upper address bit selects the reverse half
  stpti_pkg::entry_t mem [2*stpti_pkg::TableDepth];
  stpti_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/stpti_div.sv
// ----------------------------------------------------------------------------
// stpti_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QuotW bits, so the upper dividend bits seed the remainder directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpti_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [stpti_pkg::ProdW-1:0]   dividend_i,
  input  wire logic [stpti_pkg::ValW-1:0]    divisor_i,
  output logic                               done_o,
  output logic [stpti_pkg::QuotW-1:0]        quot_o
);

  logic [stpti_pkg::ValW-1:0]  rem_q;
  logic [stpti_pkg::QuotW-1:0] dvd_q;
  logic [stpti_pkg::ValW-1:0]  dvs_q;
  logic [stpti_pkg::QuotW-1:0] quot_q;
  logic [stpti_pkg::StepW-1:0] cnt_q;
  logic                        done_q;
  logic [stpti_pkg::ValW+1:0]  diff;
  logic                        borrow;

  assign diff   = {1'b0, rem_q, dvd_q[stpti_pkg::QuotW-1]} - {2'b00, dvs_q};
  assign borrow = diff[stpti_pkg::ValW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= stpti_pkg::StepW'(stpti_pkg::QuotW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - stpti_pkg::StepW'(1);
        if (cnt_q == stpti_pkg::StepW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[stpti_pkg::ProdW-2:stpti_pkg::QuotW];
      dvd_q  <= dividend_i[stpti_pkg::QuotW-1:0];
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      // keep the difference when no borrow, else shift the next bit in
      if (!borrow) begin
        rem_q <= diff[stpti_pkg::ValW-1:0];
      end else begin
        rem_q <= {rem_q[stpti_pkg::ValW-2:0], dvd_q[stpti_pkg::QuotW-1]};
      end
      dvd_q  <= {dvd_q[stpti_pkg::QuotW-2:0], 1'b0};
      quot_q <= {quot_q[stpti_pkg::QuotW-2:0], ~borrow};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire
